@@ rtl/core/dssu_pkg.sv @@
`default_nettype none
package dssu_pkg;

  localparam int NUM_SYN_DEF  = 1024;
  localparam int EXP_ITER_DEF = 16;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [40:0] MAG_CAP = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_SPIKE  = 2'd1,
    FN_RESET  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  localparam logic CFG_DELTA_T     = 1'b0;
  localparam logic CFG_DEFAULT_USE = 1'b1;

  // U, D, F per synapse type: II, IE, EI, EE
  localparam logic [30:0] TYPE_USE [4] = '{31'd343597384, 31'd268435456,
                                           31'd53687091,  31'd536870912};
  localparam logic [31:0] TYPE_DEP [4] = '{32'd38654706,  32'd187904819,
                                           32'd33554432,  32'd295279002};
  localparam logic [31:0] TYPE_FAC [4] = '{32'd16106127,  32'd5368709,
                                           32'd322122547, 32'd13421773};

  // floor((2^32-1)/i), one correction step recovers the exact quotient
  localparam logic [31:0] RECIP [0:32] = '{
    32'd0,
    32'hFFFF_FFFF / 32'd1,  32'hFFFF_FFFF / 32'd2,  32'hFFFF_FFFF / 32'd3,
    32'hFFFF_FFFF / 32'd4,  32'hFFFF_FFFF / 32'd5,  32'hFFFF_FFFF / 32'd6,
    32'hFFFF_FFFF / 32'd7,  32'hFFFF_FFFF / 32'd8,  32'hFFFF_FFFF / 32'd9,
    32'hFFFF_FFFF / 32'd10, 32'hFFFF_FFFF / 32'd11, 32'hFFFF_FFFF / 32'd12,
    32'hFFFF_FFFF / 32'd13, 32'hFFFF_FFFF / 32'd14, 32'hFFFF_FFFF / 32'd15,
    32'hFFFF_FFFF / 32'd16, 32'hFFFF_FFFF / 32'd17, 32'hFFFF_FFFF / 32'd18,
    32'hFFFF_FFFF / 32'd19, 32'hFFFF_FFFF / 32'd20, 32'hFFFF_FFFF / 32'd21,
    32'hFFFF_FFFF / 32'd22, 32'hFFFF_FFFF / 32'd23, 32'hFFFF_FFFF / 32'd24,
    32'hFFFF_FFFF / 32'd25, 32'hFFFF_FFFF / 32'd26, 32'hFFFF_FFFF / 32'd27,
    32'hFFFF_FFFF / 32'd28, 32'hFFFF_FFFF / 32'd29, 32'hFFFF_FFFF / 32'd30,
    32'hFFFF_FFFF / 32'd31, 32'hFFFF_FFFF / 32'd32
  };

  typedef struct packed {
    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic        div_load;
    logic [33:0] div_rem;
    logic [40:0] div_num;
    logic [33:0] div_den;
    logic [5:0]  div_steps;
  } alu_cmd_t;

  typedef struct packed {
    logic [63:0] prod;
    logic        div_busy;
    logic [40:0] quo;
    logic [33:0] rem;
  } alu_res_t;

endpackage
`default_nettype wire

@@ rtl/core/dssu_alu.sv @@
`default_nettype none
module dssu_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  dssu_pkg::alu_cmd_t cmd,
  output dssu_pkg::alu_res_t res
);
  import dssu_pkg::*;

  logic [63:0] prod_r;
  logic [33:0] rem_r;
  logic [33:0] den_r;
  logic [40:0] num_r;
  logic [40:0] quo_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [34:0] trial;

  assign trial = {rem_r, num_r[40]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.div_load) begin
      busy_r <= 1'b1;
      cnt_r  <= cmd.div_steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= cmd.mul_a * cmd.mul_b;
    end
    if (cmd.div_load) begin
      rem_r <= cmd.div_rem;
      num_r <= cmd.div_num;
      den_r <= cmd.div_den;
      quo_r <= '0;
    end else if (busy_r) begin
      if (!trial[34]) begin
        rem_r <= trial[33:0];
      end else begin
        rem_r <= {rem_r[32:0], num_r[40]};
      end
      quo_r <= {quo_r[39:0], ~trial[34]};
      num_r <= {num_r[39:0], 1'b0};
    end
  end

  assign res.prod     = prod_r;
  assign res.div_busy = busy_r;
  assign res.quo      = quo_r;
  assign res.rem      = rem_r;

endmodule
`default_nettype wire

@@ rtl/core/dynamic_synapse_spike_update_unit.sv @@
`default_nettype none
// Dynamic synapse table with short-term plasticity. One operation at a time:
// in_ready is high only while the sequencer is idle. A spike uses the shared
// multiplier and one-bit-per-cycle divider, which run the two interval
// divisions, two 16-term exponentials and the weight division in turn; a
// spike on a synapse with no earlier spike goes straight to the weight
// step. After reset the table is swept once before the first transfer is
// taken. A finished result waits in the output register while the next item
// is taken. Configuration writes are taken at any time.
module dynamic_synapse_spike_update_unit #(
  parameter int NUM_SYNAPSES   = dssu_pkg::NUM_SYN_DEF,
  parameter int EXP_ITERATIONS = dssu_pkg::EXP_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [9:0]         in_synapse_index,
  input  logic [47:0]        in_current_step,
  input  logic [1:0]         in_syn_type,
  input  logic signed [31:0] in_weight,
  input  logic [31:0]        in_decay_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_index_out,
  output logic signed [31:0] out_psr_out,
  output logic [30:0]        out_use_out,
  output logic [30:0]        out_recovered_out,
  output logic               out_saturated
);
  import dssu_pkg::*;

  localparam int AW = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;

  typedef struct packed {
    logic [47:0] last_step;
    logic        seen;
    logic [30:0] use_v;
    logic [30:0] rec_v;
    logic [1:0]  styp;
    logic [31:0] weight;
    logic [31:0] decay;
    logic [31:0] psr;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_ISI_A, S_ISI_B, S_ISI_C, S_EXP_CHK, S_DIV_X,
    S_DIV_K, S_T_MUL, S_T_REC, S_T_COR, S_T_ACC, S_EXP_FIN, S_UPD1, S_UPD2,
    S_UPD3, S_UPD4, S_UPD5, S_UR, S_PM, S_PD, S_DIV_P, S_PSR, S_WB, S_FIN
  } state_t;

  state_t      state_r;
  entry_t      mem [NUM_SYNAPSES];
  entry_t      rd_data_r;
  entry_t      wb_r;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] mem_ra;
  logic        mem_we;

  logic [27:0] delta_t_r;
  logic [30:0] def_use_r;

  logic [9:0]  idx_r;
  func_t       func_r;
  logic [47:0] step_r;
  logic [1:0]  type_r;
  logic [31:0] weight_r;
  logic [31:0] decay_r;

  logic [30:0] u_r, r_r, ed_r, ef_r, term_r;
  logic [63:0] isi_r;
  logic [51:0] lo_r;
  logic        sel_f_r;
  logic [5:0]  k_r;
  logic [29:0] f_r, n_r, q0_r;
  logic signed [32:0] sum_r;
  logic [5:0]  iter_r;
  logic [40:0] mag_r;

  logic [31:0] rs_psr;
  logic [30:0] rs_use, rs_rec;
  logic        rs_sat;

  logic        out_valid_r;
  logic [9:0]  out_index_r;
  logic [31:0] out_psr_r;
  logic [30:0] out_use_r, out_rec_r;
  logic        out_sat_r;

  alu_cmd_t    cmd;
  alu_res_t    res;

  dssu_alu u_alu (.clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res));

  // datapath helpers
  logic [31:0] tau;
  logic [30:0] uu;
  logic [47:0] diff;
  logic [75:0] isi_full;
  logic [30:0] def_use_c;
  logic [31:0] abs_w;
  logic [61:0] p_v;
  logic [33:0] dec_v;
  logic [31:0] nres;
  logic [29:0] q_v;
  logic [30:0] sum_cl;
  logic [30:0] e_val;
  logic [31:0] u_sum;
  logic [42:0] psr_sum;
  logic        psr_ovf;
  logic [31:0] psr_sat;
  logic        in_range;

  always_comb begin
    tau       = sel_f_r ? TYPE_FAC[rd_data_r.styp] : TYPE_DEP[rd_data_r.styp];
    uu        = TYPE_USE[rd_data_r.styp];
    diff      = step_r - rd_data_r.last_step;
    isi_full  = {res.prod[51:0], 24'd0} + {24'd0, lo_r};
    def_use_c = (def_use_r > ONE_Q30) ? ONE_Q30 : def_use_r;
    abs_w     = rd_data_r.weight[31] ? (~rd_data_r.weight + 32'd1) : rd_data_r.weight;
    p_v       = res.prod[61:0];
    dec_v     = {rd_data_r.decay, 2'b00};
    nres      = {2'b00, n_r} - res.prod[31:0];
    q_v       = q0_r + ((nres >= {26'd0, iter_r}) ? 30'd1 : 30'd0);
    if (sum_r < 0) begin
      sum_cl = '0;
    end else if (sum_r > $signed({2'b00, ONE_Q30})) begin
      sum_cl = ONE_Q30;
    end else begin
      sum_cl = sum_r[30:0];
    end
    e_val     = sum_cl >> k_r;
    u_sum     = {1'b0, uu} + {1'b0, res.prod[60:30]};
    if (rd_data_r.weight[31]) begin
      psr_sum = {{11{rd_data_r.psr[31]}}, rd_data_r.psr} - {2'b00, mag_r};
    end else begin
      psr_sum = {{11{rd_data_r.psr[31]}}, rd_data_r.psr} + {2'b00, mag_r};
    end
    psr_ovf   = (psr_sum[42:31] != {12{psr_sum[42]}});
    psr_sat   = psr_ovf ? (psr_sum[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : psr_sum[31:0];
    in_range  = (32'(in_synapse_index) < NUM_SYNAPSES);
  end

  // shared unit commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_ISI_A: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {8'd0, diff[23:0]};
        cmd.mul_b  = {4'd0, delta_t_r};
      end
      S_ISI_B: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {8'd0, diff[47:24]};
        cmd.mul_b  = {4'd0, delta_t_r};
      end
      S_EXP_CHK: begin
        cmd.div_rem   = isi_r[38:5];
        cmd.div_num   = {isi_r[4:0], 36'd0};
        cmd.div_den   = {2'b00, tau};
        cmd.div_steps = 6'd35;
        cmd.div_load  = !((tau == '0) || (isi_r >= {27'd0, tau, 5'd0}));
      end
      S_DIV_X: begin
        cmd.div_rem   = {5'd0, res.quo[34:6]};
        cmd.div_num   = {res.quo[5:0], 35'd0};
        cmd.div_den   = {4'd0, LN2_Q30};
        cmd.div_steps = 6'd6;
        cmd.div_load  = !res.div_busy;
      end
      S_T_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, term_r};
        cmd.mul_b  = {2'b00, f_r};
      end
      S_T_REC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {2'b00, res.prod[59:30]};
        cmd.mul_b  = RECIP[iter_r];
      end
      S_T_COR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {2'b00, res.prod[61:32]};
        cmd.mul_b  = {26'd0, iter_r};
      end
      S_UPD1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, r_r};
        cmd.mul_b  = {1'b0, ONE_Q30 - u_r};
      end
      S_UPD2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, ONE_Q30 - res.prod[60:30]};
        cmd.mul_b  = {1'b0, ed_r};
      end
      S_UPD3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, u_r};
        cmd.mul_b  = {1'b0, ONE_Q30 - uu};
      end
      S_UPD4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, res.prod[60:30]};
        cmd.mul_b  = {1'b0, ef_r};
      end
      S_UR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = {1'b0, u_r};
        cmd.mul_b  = {1'b0, r_r};
      end
      S_PM: begin
        cmd.mul_en = 1'b1;
        cmd.mul_a  = abs_w;
        cmd.mul_b  = {1'b0, res.prod[60:30]};
      end
      S_PD: begin
        cmd.div_rem   = {13'd0, p_v[61:41]};
        cmd.div_num   = p_v[40:0];
        cmd.div_den   = dec_v;
        cmd.div_steps = 6'd41;
        cmd.div_load  = (dec_v != '0) && ({13'd0, p_v[61:41]} < dec_v);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // entry store
  assign mem_ra = (state_r == S_IDLE) ? AW'(in_synapse_index) : addr_r;
  assign mem_we = (state_r == S_CLR) || (state_r == S_WB);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[(state_r == S_CLR) ? clr_cnt_r : addr_r] <= (state_r == S_CLR) ? '0 : wb_r;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_t_r <= 28'd26844;
      def_use_r <= 31'd429496730;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELTA_T:     delta_t_r <= cfg_data[27:0];
        CFG_DEFAULT_USE: def_use_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == AW'(NUM_SYNAPSES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            idx_r    <= in_synapse_index;
            addr_r   <= AW'(in_synapse_index);
            func_r   <= func_t'(in_func);
            step_r   <= in_current_step;
            type_r   <= in_syn_type;
            weight_r <= in_weight;
            decay_r  <= in_decay_value;
            if (in_range) begin
              state_r <= S_RD;
            end else begin
              rs_psr  <= '0;
              rs_use  <= '0;
              rs_rec  <= '0;
              rs_sat  <= 1'b0;
              state_r <= S_FIN;
            end
          end
        end
        S_RD: begin
          rs_sat <= 1'b0;
          unique case (func_r)
            FN_CREATE, FN_RESET: begin
              wb_r           <= rd_data_r;
              wb_r.last_step <= '0;
              wb_r.seen      <= 1'b0;
              wb_r.use_v     <= def_use_c;
              wb_r.rec_v     <= ONE_Q30;
              wb_r.psr       <= '0;
              if (func_r == FN_CREATE) begin
                wb_r.styp   <= type_r;
                wb_r.weight <= weight_r;
                wb_r.decay  <= decay_r;
              end
              rs_psr  <= '0;
              rs_use  <= def_use_c;
              rs_rec  <= ONE_Q30;
              state_r <= S_WB;
            end
            FN_NOP: begin
              rs_psr  <= rd_data_r.psr;
              rs_use  <= rd_data_r.use_v;
              rs_rec  <= rd_data_r.rec_v;
              state_r <= S_FIN;
            end
            FN_SPIKE: begin
              u_r     <= (rd_data_r.use_v > ONE_Q30) ? ONE_Q30 : rd_data_r.use_v;
              r_r     <= (rd_data_r.rec_v > ONE_Q30) ? ONE_Q30 : rd_data_r.rec_v;
              state_r <= rd_data_r.seen ? S_ISI_A : S_UR;
            end
          endcase
        end
        S_ISI_A: state_r <= S_ISI_B;
        S_ISI_B: begin
          lo_r    <= res.prod[51:0];
          state_r <= S_ISI_C;
        end
        S_ISI_C: begin
          isi_r   <= (isi_full[75:64] != '0) ? '1 : isi_full[63:0];
          sel_f_r <= 1'b0;
          state_r <= S_EXP_CHK;
        end
        S_EXP_CHK: begin
          if (cmd.div_load) begin
            state_r <= S_DIV_X;
          end else begin
            sum_r   <= '0;
            k_r     <= '0;
            state_r <= S_EXP_FIN;
          end
        end
        S_DIV_X: begin
          if (!res.div_busy) begin
            state_r <= S_DIV_K;
          end
        end
        S_DIV_K: begin
          if (!res.div_busy) begin
            if (res.quo[5:0] >= 6'd31) begin
              sum_r   <= '0;
              k_r     <= '0;
              state_r <= S_EXP_FIN;
            end else begin
              k_r     <= res.quo[5:0];
              f_r     <= res.rem[29:0];
              term_r  <= ONE_Q30;
              sum_r   <= $signed({2'b00, ONE_Q30});
              iter_r  <= 6'd1;
              state_r <= S_T_MUL;
            end
          end
        end
        S_T_MUL: state_r <= S_T_REC;
        S_T_REC: begin
          n_r     <= res.prod[59:30];
          state_r <= S_T_COR;
        end
        S_T_COR: begin
          q0_r    <= res.prod[61:32];
          state_r <= S_T_ACC;
        end
        S_T_ACC: begin
          term_r <= {1'b0, q_v};
          if (iter_r[0]) begin
            sum_r <= sum_r - $signed({3'b000, q_v});
          end else begin
            sum_r <= sum_r + $signed({3'b000, q_v});
          end
          if (iter_r == 6'(EXP_ITERATIONS)) begin
            state_r <= S_EXP_FIN;
          end else begin
            iter_r  <= iter_r + 6'd1;
            state_r <= S_T_MUL;
          end
        end
        S_EXP_FIN: begin
          if (!sel_f_r) begin
            ed_r    <= e_val;
            sel_f_r <= 1'b1;
            state_r <= S_EXP_CHK;
          end else begin
            ef_r    <= e_val;
            state_r <= S_UPD1;
          end
        end
        S_UPD1: state_r <= S_UPD2;
        S_UPD2: state_r <= S_UPD3;
        S_UPD3: begin
          r_r     <= ONE_Q30 - res.prod[60:30];
          state_r <= S_UPD4;
        end
        S_UPD4: state_r <= S_UPD5;
        S_UPD5: begin
          u_r     <= (u_sum > {1'b0, ONE_Q30}) ? ONE_Q30 : u_sum[30:0];
          state_r <= S_UR;
        end
        S_UR: state_r <= S_PM;
        S_PM: state_r <= S_PD;
        S_PD: begin
          if (cmd.div_load) begin
            state_r <= S_DIV_P;
          end else begin
            mag_r   <= (p_v != '0) ? MAG_CAP : '0;
            state_r <= S_PSR;
          end
        end
        S_DIV_P: begin
          if (!res.div_busy) begin
            mag_r   <= (res.quo > MAG_CAP) ? MAG_CAP : res.quo;
            state_r <= S_PSR;
          end
        end
        S_PSR: begin
          wb_r           <= rd_data_r;
          wb_r.psr       <= psr_sat;
          wb_r.use_v     <= u_r;
          wb_r.rec_v     <= r_r;
          wb_r.last_step <= step_r;
          wb_r.seen      <= 1'b1;
          rs_psr         <= psr_sat;
          rs_use         <= u_r;
          rs_rec         <= r_r;
          rs_sat         <= psr_ovf;
          state_r        <= S_WB;
        end
        S_WB: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_index_r <= idx_r;
            out_psr_r   <= rs_psr;
            out_use_r   <= rs_use;
            out_rec_r   <= rs_rec;
            out_sat_r   <= rs_sat;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_index_out     = out_index_r;
  assign out_psr_out       = out_psr_r;
  assign out_use_out       = out_use_r;
  assign out_recovered_out = out_rec_r;
  assign out_saturated     = out_sat_r;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import dssu_pkg::*;

  localparam int NSYN = 1024;
  localparam longint unsigned ONE = 64'd1 << 30;
  localparam longint unsigned LN2 = 64'd744261118;

  typedef struct {
    logic [9:0]         idx;
    logic signed [31:0] psr;
    logic [30:0]        use_q;
    logic [30:0]        rec;
    logic               sat;
  } syn_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_DELTA_T;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = FN_CREATE;
  logic [9:0] in_synapse_index = '0;
  logic [47:0] in_current_step = '0;
  logic [1:0] in_syn_type = '0;
  logic signed [31:0] in_weight = '0;
  logic [31:0] in_decay_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_index_out;
  logic signed [31:0] out_psr_out;
  logic [30:0] out_use_out;
  logic [30:0] out_recovered_out;
  logic out_saturated;

  dynamic_synapse_spike_update_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // synapse table as predicted
  longint unsigned last_step [NSYN];
  bit              seen      [NSYN];
  bit              created   [NSYN];
  bit [31:0]       rec_tab   [NSYN];
  bit [31:0]       util_tab  [NSYN];
  bit [31:0]       base_tab  [NSYN];
  bit [31:0]       dep_tab   [NSYN];
  bit [31:0]       fac_tab   [NSYN];
  bit [31:0]       wgt_tab   [NSYN];
  bit [31:0]       dcy_tab   [NSYN];
  bit [31:0]       psr_tab   [NSYN];
  longint unsigned step_len = 26844;
  longint unsigned dflt_use = 429496730;

  syn_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint unsigned clamp1(longint unsigned v);
    return v > ONE ? ONE : v;
  endfunction

  function automatic longint unsigned exp_neg_q30(longint unsigned x);
    longint unsigned k, f, term;
    longint acc;
    k = x / LN2;
    f = x - k * LN2;
    if (k >= 31) return 0;
    term = ONE;
    acc = longint'(ONE);
    for (int i = 1; i <= EXP_ITERATIONS_TB; i++) begin
      term = ((term * f) >> 30) / longint'(i);
      if (i % 2) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(ONE)) acc = longint'(ONE);
    return longint'(acc) >> k;
  endfunction

  localparam int EXP_ITERATIONS_TB = 16;

  function automatic longint unsigned relax_factor(longint unsigned isi, longint unsigned tau);
    longint unsigned ip, rm;
    if (tau == 0 || isi >= (tau << 5)) return 0;
    ip = isi / tau;
    rm = isi % tau;
    return exp_neg_q30((ip << 30) | ((rm << 30) / tau));
  endfunction

  function automatic void clear_dyn(int i);
    util_tab[i] = 32'(clamp1(dflt_use));
    rec_tab[i] = 32'(ONE);
    seen[i] = 1'b0;
    last_step[i] = 0;
    psr_tab[i] = 0;
  endfunction

  function automatic syn_result_t synapse_update(logic [1:0] fn, int i, longint unsigned step,
                                                 logic [1:0] ty, logic [31:0] w_in,
                                                 logic [31:0] d_in);
    syn_result_t res;
    longint unsigned u, r, diff, isi, ed, ef, a, uu, ur, mag, dec;
    longint p, w;
    res.sat = 1'b0;
    if (fn == FN_CREATE) begin
      wgt_tab[i] = w_in;
      dcy_tab[i] = d_in;
      base_tab[i] = {1'b0, TYPE_USE[ty]};
      dep_tab[i] = TYPE_DEP[ty];
      fac_tab[i] = TYPE_FAC[ty];
      clear_dyn(i);
    end else if (fn == FN_RESET) begin
      clear_dyn(i);
    end else if (fn == FN_SPIKE) begin
      u = clamp1(util_tab[i]);
      r = clamp1(rec_tab[i]);
      if (seen[i]) begin
        diff = (step - last_step[i]) & 64'hFFFF_FFFF_FFFF;
        if (step_len != 0 && diff > 64'hFFFF_FFFF_FFFF_FFFF / step_len)
          isi = 64'hFFFF_FFFF_FFFF_FFFF;
        else
          isi = diff * step_len;
        ed = relax_factor(isi, dep_tab[i]);
        ef = relax_factor(isi, fac_tab[i]);
        a = (r * (ONE - u)) >> 30;
        r = clamp1(ONE - (((ONE - a) * ed) >> 30));
        uu = clamp1(base_tab[i]);
        u = clamp1(uu + ((((u * (ONE - uu)) >> 30) * ef) >> 30));
      end
      ur = (u * r) >> 30;
      w = longint'($signed(wgt_tab[i]));
      mag = w < 0 ? -w : w;
      p = mag * ur;
      dec = longint'(dcy_tab[i]) << 2;
      if (dec == 0) mag = (p != 0) ? (64'd1 << 40) : 0;
      else mag = longint'(p) / dec;
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      p = longint'($signed(psr_tab[i]));
      if (w < 0) p -= longint'(mag);
      else p += longint'(mag);
      if (p > 64'sd2147483647) begin
        p = 64'sd2147483647;
        res.sat = 1'b1;
      end
      if (p < -64'sd2147483648) begin
        p = -64'sd2147483648;
        res.sat = 1'b1;
      end
      psr_tab[i] = 32'(p);
      util_tab[i] = 32'(u);
      rec_tab[i] = 32'(r);
      last_step[i] = step;
      seen[i] = 1'b1;
    end
    res.idx = 10'(i);
    res.psr = psr_tab[i];
    res.use_q = util_tab[i][30:0];
    res.rec = rec_tab[i][30:0];
    return res;
  endfunction

  task automatic report(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected transfer, index", out_index_out, 0);
      end else begin
        syn_result_t e;
        e = pending_results.pop_front();
        if (out_index_out !== e.idx) report("index", out_index_out, e.idx);
        if (out_psr_out !== e.psr) report("psr", out_psr_out, e.psr);
        if (out_use_out !== e.use_q) report("use", out_use_out, e.use_q);
        if (out_recovered_out !== e.rec) report("recovered", out_recovered_out, e.rec);
        if (out_saturated !== e.sat) report("saturated", out_saturated, e.sat);
      end
    end
  end

  task automatic send_item(logic [1:0] fn, int i, longint unsigned step, logic [1:0] ty,
                           logic [31:0] w, logic [31:0] d);
    in_valid <= 1'b1;
    in_func <= fn;
    in_synapse_index <= 10'(i);
    in_current_step <= 48'(step);
    in_syn_type <= ty;
    in_weight <= w;
    in_decay_value <= d;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(synapse_update(fn, i, step & 64'hFFFF_FFFF_FFFF, ty, w, d));
    if (fn == FN_CREATE) created[i] = 1'b1;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DELTA_T) step_len = val[27:0];
    else dflt_use = val;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(FN_CREATE, 0, 0, 2'd0, 32'h7FFF_FFFF, 32'd1);
    send_item(FN_SPIKE, 0, 100, 0, 0, 0);
    send_item(FN_SPIKE, 0, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
    send_item(FN_SPIKE, 0, 50, 0, 0, 0);
    send_item(FN_CREATE, 1023, 0, 2'd1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(FN_SPIKE, 1023, 10, 0, 0, 0);
    send_item(FN_SPIKE, 1023, 500, 0, 0, 0);
    send_item(FN_NOP, 1023, 0, 0, 0, 0);
    send_item(FN_RESET, 1023, 0, 0, 0, 0);
    send_item(FN_SPIKE, 1023, 7, 0, 0, 0);
    send_item(FN_CREATE, 5, 0, 2'd2, 32'h8000_0000, 32'd0);
    send_item(FN_SPIKE, 5, 1, 0, 0, 0);
    send_item(FN_SPIKE, 5, 1, 0, 0, 0);
    send_item(FN_CREATE, 6, 0, 2'd3, 32'd0, 32'd0);
    send_item(FN_SPIKE, 6, 3, 0, 0, 0);
    send_item(FN_CREATE, 7, 0, 2'd3, 32'h0100_0000, 32'h1000_0000);
    send_item(FN_SPIKE, 7, 1000, 0, 0, 0);
    send_item(FN_SPIKE, 7, 1200, 0, 0, 0);
    send_item(FN_SPIKE, 7, 48'h8000_0000_0000, 0, 0, 0);
    send_item(FN_NOP, 7, 0, 0, 0, 0);
    send_item(FN_RESET, 300, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_config();
    write_reg(CFG_DEFAULT_USE, 31'h7FFF_FFFF);
    write_reg(CFG_DELTA_T, 31'h7FFF_FFFF);
    send_item(FN_CREATE, 9, 0, 2'd0, 32'h1234_5678, 32'h0100_0000);
    send_item(FN_SPIKE, 9, 1, 0, 0, 0);
    send_item(FN_SPIKE, 9, 2, 0, 0, 0);
    drain();
    write_reg(CFG_DEFAULT_USE, 31'd0);
    write_reg(CFG_DELTA_T, 31'd1);
    send_item(FN_RESET, 9, 0, 0, 0, 0);
    send_item(FN_SPIKE, 9, 10, 0, 0, 0);
    send_item(FN_SPIKE, 9, 1000, 0, 0, 0);
    drain();
    write_reg(CFG_DEFAULT_USE, 31'h4000_0000);
    write_reg(CFG_DELTA_T, 31'd26844);
    send_item(FN_RESET, 9, 0, 0, 0, 0);
    send_item(FN_SPIKE, 9, 10, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle, int stall, logic [30:0] dt,
                                   logic [30:0] du);
    int pool [24];
    longint unsigned step_at [24];
    int k, i, sel;
    longint unsigned st;
    logic [31:0] w, d;
    logic [1:0] fn;
    write_reg(CFG_DELTA_T, dt);
    write_reg(CFG_DEFAULT_USE, du);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    foreach (pool[j]) begin
      pool[j] = $urandom_range(NSYN - 1);
      step_at[j] = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
    end
    for (int n_i = 0; n_i < n; n_i++) begin
      k = $urandom_range(23);
      i = pool[k];
      w = $urandom;
      d = ($urandom_range(3) == 0) ? $urandom_range(1 << 20) : $urandom;
      sel = $urandom_range(99);
      if (!created[i] || sel < 10) fn = FN_CREATE;
      else if (sel < 18) fn = FN_RESET;
      else if (sel < 23) fn = FN_NOP;
      else fn = FN_SPIKE;
      case ($urandom_range(9))
        0: st = {$urandom, $urandom};
        1: st = step_at[k];
        2: st = step_at[k] + $urandom_range(20000, 200000);
        default: st = step_at[k] + $urandom_range(1, 4000);
      endcase
      st &= 64'hFFFF_FFFF_FFFF;
      if (fn == FN_SPIKE) step_at[k] = st;
      if (fn == FN_NOP && !created[i]) fn = FN_RESET;
      send_item(fn, i, st, 2'($urandom), w, d);
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_random_phase(440, 0, 0, 31'd26844, 31'd429496730);
    test_random_phase(440, 52, 0, 31'($urandom), 31'($urandom_range(32'h4000_0000)));
    test_random_phase(440, 0, 52, 31'd200000, 31'h4000_0000);
    test_random_phase(440, 8, 8, 31'd1000, 31'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule
